// ===== hw/rtl/esc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the sensor compensation block.
package esc_pkg;

    localparam int QueueDepth = 2;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 64;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL       = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_HIGH = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_LAST = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM_CAL        = 3'd4;

    localparam logic [31:0] K_P_OFS    = 32'd64000;
    localparam logic [31:0] K_P_BASE   = 32'd1048576;
    localparam logic [31:0] K_P_SCALE  = 32'd3125;
    localparam logic [31:0] K_HALF15   = 32'd32768;
    localparam logic [31:0] K_H_OFS    = 32'd76800;
    localparam logic [31:0] K_RND14    = 32'd16384;
    localparam logic [31:0] K_H_BIAS   = 32'd2097152;
    localparam logic [31:0] K_H_MAX    = 32'd419430400;

    // calibration coefficients, widened to 32 bits
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_cal;

    // queued item, with the simple raw-value terms already formed
    typedef struct packed {
        logic [31:0] dt1;  // (adc_t >> 3) - (T1 << 1)
        logic [31:0] dd;   // (adc_t >> 4) - T1
        logic [31:0] pd;   // 1048576 - adc_p
        logic [31:0] hs;   // adc_h << 14
    } t_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        mulw = p[31:0];
    endfunction

endpackage

// ===== hw/rtl/esc_fifo.sv =====
// Small queue between the intake stage and the compute sequencer.
module esc_fifo #(
    parameter int DEPTH = esc_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  esc_pkg::t_item       i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output esc_pkg::t_item       o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    esc_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push && !o_full) - CW'(i_pop && !o_empty);
        end
    end
endmodule

// ===== hw/rtl/esc_front.sv =====
// Intake stage: takes raw samples, forms the raw-value terms and feeds the queue.
module esc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [19:0]    i_raw_temperature,
    input  logic [19:0]    i_raw_pressure,
    input  logic [15:0]    i_raw_humidity,
    input  esc_pkg::t_cal  i_cal,
    input  logic           i_full,
    output logic           o_push,
    output esc_pkg::t_item o_item
);
    logic           r_v;
    esc_pkg::t_item r_item;
    esc_pkg::t_item n_item;

    assign o_push  = r_v && !i_full;
    assign o_ready = !r_v || o_push;
    assign o_item  = r_item;

    always_comb begin
        n_item.dt1 = {15'd0, i_raw_temperature[19:3]} - (i_cal.t1 << 1);
        n_item.dd  = {16'd0, i_raw_temperature[19:4]} - i_cal.t1;
        n_item.pd  = esc_pkg::K_P_BASE - {12'd0, i_raw_pressure};
        n_item.hs  = {2'd0, i_raw_humidity, 14'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end
endmodule

// ===== hw/rtl/esc_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module esc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esc_pkg::t_div_req i_req,
    output esc_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] rem_sh, diff;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule

// ===== hw/rtl/esc_back.sv =====
// Compute sequencer: at most one multiply per step, divider for pressure, output register.
module esc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  esc_pkg::t_cal        i_cal,
    input  logic                 i_empty,
    input  esc_pkg::t_item       i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_temperature_centi,
    output logic [31:0]          o_pressure_pa,
    output logic                 o_pressure_invalid,
    output logic [16:0]          o_humidity_q10
);
    typedef enum logic [27:0] {
        S_IDLE = 28'd1 << 0,  S_T1  = 28'd1 << 1,  S_T2  = 28'd1 << 2,
        S_T3   = 28'd1 << 3,  S_T4  = 28'd1 << 4,  S_P1  = 28'd1 << 5,
        S_P2   = 28'd1 << 6,  S_P3  = 28'd1 << 7,  S_P4  = 28'd1 << 8,
        S_P5   = 28'd1 << 9,  S_P6  = 28'd1 << 10, S_P7  = 28'd1 << 11,
        S_DST  = 28'd1 << 12, S_DIV = 28'd1 << 13, S_P8  = 28'd1 << 14,
        S_P9   = 28'd1 << 15, S_P10 = 28'd1 << 16, S_P11 = 28'd1 << 17,
        S_P12  = 28'd1 << 18, S_H1  = 28'd1 << 19, S_H2  = 28'd1 << 20,
        S_H3   = 28'd1 << 21, S_H4  = 28'd1 << 22, S_H5  = 28'd1 << 23,
        S_H6   = 28'd1 << 24, S_H7  = 28'd1 << 25, S_H8  = 28'd1 << 26,
        S_DONE = 28'd1 << 27
    } t_state;

    t_state r_state;
    esc_pkg::t_item r_item;
    logic [31:0] r_fine, r_temp, r_pa, r_pb, r_x, r_y, r_pres, r_ha, r_hb, r_hc, r_he;
    logic [31:0] r_hx;
    logic [16:0] r_hum;
    logic        r_inv, r_dbl;
    logic        out_free;
    logic [31:0] hsum;
    esc_pkg::t_div_req div_req;
    esc_pkg::t_div_rsp div_rsp;

    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // large dividend: divide first, double afterwards
    assign div_req.start    = (r_state == S_DST);
    assign div_req.dividend = r_pres[31] ? r_pres : (r_pres << 1);
    assign div_req.divisor  = r_y;

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign hsum = r_hx - esc_pkg::asr(esc_pkg::mulw(r_hc, i_cal.h1), 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_T1;
                S_T1:   r_state <= S_T2;
                S_T2:   r_state <= S_T3;
                S_T3:   r_state <= S_T4;
                S_T4:   r_state <= S_P1;
                S_P1:   r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_P4;
                S_P4:   r_state <= S_P5;
                S_P5:   r_state <= S_P6;
                S_P6:   r_state <= S_P7;
                S_P7:   r_state <= (r_y == '0) ? S_H1 : S_DST;
                S_DST:  r_state <= S_DIV;
                S_DIV:  if (div_rsp.done) r_state <= S_P8;
                S_P8:   r_state <= S_P9;
                S_P9:   r_state <= S_P10;
                S_P10:  r_state <= S_P11;
                S_P11:  r_state <= S_P12;
                S_P12:  r_state <= S_H1;
                S_H1:   r_state <= S_H2;
                S_H2:   r_state <= S_H3;
                S_H3:   r_state <= S_H4;
                S_H4:   r_state <= S_H5;
                S_H5:   r_state <= S_H6;
                S_H6:   r_state <= S_H7;
                S_H7:   r_state <= S_H8;
                S_H8:   r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (!i_empty) r_item <= i_item;
            S_T1: begin
                r_pa  <= esc_pkg::asr(esc_pkg::mulw(r_item.dt1, i_cal.t2), 11);
                r_inv <= 1'b0;
            end
            S_T2: r_x <= esc_pkg::asr(esc_pkg::mulw(r_item.dd, r_item.dd), 12);
            S_T3: r_fine <= r_pa + esc_pkg::asr(esc_pkg::mulw(r_x, i_cal.t3), 14);
            S_T4: begin
                r_temp <= esc_pkg::asr(esc_pkg::mulw(r_fine, 32'd5) + 32'd128, 8);
                r_pa   <= esc_pkg::asr(r_fine, 1) - esc_pkg::K_P_OFS;
                r_ha   <= r_fine - esc_pkg::K_H_OFS;
            end
            S_P1: r_x <= esc_pkg::mulw(esc_pkg::asr(r_pa, 2), esc_pkg::asr(r_pa, 2));
            S_P2: r_pb <= esc_pkg::mulw(esc_pkg::asr(r_x, 11), i_cal.p6);
            S_P3: r_pb <= r_pb + (esc_pkg::mulw(r_pa, i_cal.p5) << 1);
            S_P4: begin
                r_pb <= esc_pkg::asr(r_pb, 2) + (i_cal.p4 << 16);
                r_y  <= esc_pkg::asr(esc_pkg::mulw(i_cal.p3, esc_pkg::asr(r_x, 13)), 3);
            end
            S_P5: r_y <= esc_pkg::asr(r_y + esc_pkg::asr(esc_pkg::mulw(i_cal.p2, r_pa), 1), 18);
            S_P6: r_y <= esc_pkg::asr(esc_pkg::mulw(esc_pkg::K_HALF15 + r_y, i_cal.p1), 15);
            S_P7: begin
                if (r_y == '0) begin
                    r_pres <= '0;
                    r_inv  <= 1'b1;
                end else begin
                    r_pres <= esc_pkg::mulw(r_item.pd - esc_pkg::asr(r_pb, 12),
                                            esc_pkg::K_P_SCALE);
                end
            end
            S_DST: begin
                r_dbl <= r_pres[31];
            end
            S_DIV: ;
            S_P8: r_pres <= r_dbl ? (div_rsp.quotient << 1) : div_rsp.quotient;
            S_P9: r_x <= esc_pkg::mulw(r_pres >> 3, r_pres >> 3) >> 13;
            S_P10: r_x <= esc_pkg::asr(esc_pkg::mulw(i_cal.p9, r_x), 12);
            S_P11: r_y <= esc_pkg::asr(esc_pkg::mulw(r_pres >> 2, i_cal.p8), 13);
            S_P12: r_pres <= r_pres + esc_pkg::asr(r_x + r_y + i_cal.p7, 4);
            S_H1: r_hb <= esc_pkg::asr(r_item.hs - (i_cal.h4 << 20)
                            - esc_pkg::mulw(i_cal.h5, r_ha) + esc_pkg::K_RND14, 15);
            S_H2: r_hc <= esc_pkg::asr(esc_pkg::mulw(r_ha, i_cal.h6), 10);
            S_H3: r_x <= esc_pkg::asr(esc_pkg::mulw(r_ha, i_cal.h3), 11) + esc_pkg::K_HALF15;
            S_H4: r_he <= esc_pkg::asr(esc_pkg::mulw(r_hc, r_x), 10) + esc_pkg::K_H_BIAS;
            S_H5: r_he <= esc_pkg::asr(esc_pkg::mulw(r_he, i_cal.h2) + 32'd8192, 14);
            S_H6: r_hx <= esc_pkg::mulw(r_hb, r_he);
            S_H7: r_hc <= esc_pkg::asr(esc_pkg::mulw(esc_pkg::asr(r_hx, 15),
                                                     esc_pkg::asr(r_hx, 15)), 7);
            S_H8: begin
                priority if (hsum[31]) r_hum <= '0;
                else if (hsum > esc_pkg::K_H_MAX) r_hum <= esc_pkg::K_H_MAX[28:12];
                else r_hum <= hsum[28:12];
            end
            S_DONE: begin
                if (out_free) begin
                    o_temperature_centi <= r_temp;
                    o_pressure_pa       <= r_pres;
                    o_pressure_invalid  <= r_inv;
                    o_humidity_q10      <= r_hum;
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/env_sensor_compensation.sv =====
// Top level of the environmental sensor compensation block.
// One raw sample in, one compensated result out. A sample occupies the compute sequencer
// for 24 compute steps with at most one multiply each, a step to launch the division and
// the 32 iterations of the bit-serial divider for the pressure quotient, plus a step each
// to take the sample from the queue and to load the output register. When the pressure
// divisor is zero, the division and the pressure steps after it are skipped. A result
// that is not taken holds the sequencer in its last step until the output register frees
// up. The intake stage and a small queue take new samples while the sequencer works.
// Calibration registers must be written while no sample is in flight.
module env_sensor_compensation #(
    parameter int QUEUE_DEPTH = esc_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [esc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [esc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [19:0]                   i_raw_temperature,
    input  logic [19:0]                   i_raw_pressure,
    input  logic [15:0]                   i_raw_humidity,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_temperature_centi,
    output logic [31:0]                   o_pressure_pa,
    output logic                          o_pressure_invalid,
    output logic [16:0]                   o_humidity_q10
);
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_cal_low, r_press_cal_high, r_hum_cal;
    logic [15:0] r_press_cal_last;
    esc_pkg::t_cal  cal;
    esc_pkg::t_item q_in, q_out;
    logic push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal       <= '0;
            r_press_cal_low  <= '0;
            r_press_cal_high <= '0;
            r_press_cal_last <= '0;
            r_hum_cal        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                esc_pkg::REG_TEMP_CAL:       r_temp_cal       <= i_cfg_data[47:0];
                esc_pkg::REG_PRESS_CAL_LOW:  r_press_cal_low  <= i_cfg_data;
                esc_pkg::REG_PRESS_CAL_HIGH: r_press_cal_high <= i_cfg_data;
                esc_pkg::REG_PRESS_CAL_LAST: r_press_cal_last <= i_cfg_data[15:0];
                esc_pkg::REG_HUM_CAL:        r_hum_cal        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = {16'd0, r_temp_cal[15:0]};
        cal.t2 = {{16{r_temp_cal[31]}}, r_temp_cal[31:16]};
        cal.t3 = {{16{r_temp_cal[47]}}, r_temp_cal[47:32]};
        cal.p1 = {16'd0, r_press_cal_low[15:0]};
        cal.p2 = {{16{r_press_cal_low[31]}}, r_press_cal_low[31:16]};
        cal.p3 = {{16{r_press_cal_low[47]}}, r_press_cal_low[47:32]};
        cal.p4 = {{16{r_press_cal_low[63]}}, r_press_cal_low[63:48]};
        cal.p5 = {{16{r_press_cal_high[15]}}, r_press_cal_high[15:0]};
        cal.p6 = {{16{r_press_cal_high[31]}}, r_press_cal_high[31:16]};
        cal.p7 = {{16{r_press_cal_high[47]}}, r_press_cal_high[47:32]};
        cal.p8 = {{16{r_press_cal_high[63]}}, r_press_cal_high[63:48]};
        cal.p9 = {{16{r_press_cal_last[15]}}, r_press_cal_last};
        cal.h1 = {24'd0, r_hum_cal[7:0]};
        cal.h2 = {{16{r_hum_cal[23]}}, r_hum_cal[23:8]};
        cal.h3 = {24'd0, r_hum_cal[31:24]};
        cal.h4 = {{20{r_hum_cal[43]}}, r_hum_cal[43:32]};
        cal.h5 = {{20{r_hum_cal[55]}}, r_hum_cal[55:44]};
        cal.h6 = {{24{r_hum_cal[63]}}, r_hum_cal[63:56]};
    end

    esc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_humidity    (i_raw_humidity),
        .i_cal             (cal),
        .i_full            (full),
        .o_push            (push),
        .o_item            (q_in)
    );

    esc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    esc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cal               (cal),
        .i_empty             (empty),
        .i_item              (q_out),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_pressure_invalid  (o_pressure_invalid),
        .o_humidity_q10      (o_humidity_q10)
    );
endmodule

// ===== tb/env_sensor_compensation_test.sv =====
// Self-checking testbench for the environmental sensor compensation block.
module env_sensor_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;
    localparam int FlushCycles = 80;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        inval;
        logic [16:0] hum;
    } t_comp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [esc_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [esc_pkg::CfgDataW-1:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic [15:0] i_raw_humidity;
    logic o_valid;
    logic i_ready;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_pa;
    logic o_pressure_invalid;
    logic [16:0] o_humidity_q10;

    env_sensor_compensation i_dut (.*);

    // shadow calibration
    logic [47:0] cal_temp;
    logic [63:0] cal_plo, cal_phi, cal_hum;
    logic [15:0] cal_plast;

    t_comp expected_q[$];
    int errors = 0;
    int cycles = 0;
    int results_seen = 0;
    int invalid_seen = 0;
    bit rx_hold = 0;
    bit rx_random = 1;
    int tx_gap_max = 3;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sx(input logic [63:0] r, input int lsb, input int bits);
        logic [31:0] v;
        v = 32'((r >> lsb) & ((64'd1 << bits) - 1));
        if (v[bits-1]) v = v | ~((32'd1 << bits) - 1);
        return v;
    endfunction

    function automatic logic [31:0] ux(input logic [63:0] r, input int lsb, input int bits);
        return 32'((r >> lsb) & ((64'd1 << bits) - 1));
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic t_comp compensate(input logic [19:0] rt, input logic [19:0] rp,
                                         input logic [15:0] rh);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, c, d, e, fine, sq, pres;
        t_comp r;
        t1 = ux(cal_temp, 0, 16); t2 = sx(cal_temp, 16, 16); t3 = sx(cal_temp, 32, 16);
        p1 = ux(cal_plo, 0, 16); p2 = sx(cal_plo, 16, 16);
        p3 = sx(cal_plo, 32, 16); p4 = sx(cal_plo, 48, 16);
        p5 = sx(cal_phi, 0, 16); p6 = sx(cal_phi, 16, 16);
        p7 = sx(cal_phi, 32, 16); p8 = sx(cal_phi, 48, 16);
        p9 = sx(cal_plast, 0, 16);
        h1 = ux(cal_hum, 0, 8); h2 = sx(cal_hum, 8, 16); h3 = ux(cal_hum, 24, 8);
        h4 = sx(cal_hum, 32, 12); h5 = sx(cal_hum, 44, 12); h6 = sx(cal_hum, 56, 8);

        a = sra(mul32((32'(rt) >> 3) - (t1 << 1), t2), 11);
        d = (32'(rt) >> 4) - t1;
        b = sra(mul32(sra(mul32(d, d), 12), t3), 14);
        fine = a + b;
        r.temp = sra(mul32(fine, 32'd5) + 32'd128, 8);

        a = sra(fine, 1) - 32'd64000;
        sq = mul32(sra(a, 2), sra(a, 2));
        b = mul32(sra(sq, 11), p6);
        b = b + (mul32(a, p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(mul32(p3, sra(sq, 13)), 3) + sra(mul32(p2, a), 1), 18);
        a = sra(mul32(32'd32768 + a, p1), 15);
        r.inval = (a == 0);
        if (r.inval) begin
            pres = 0;
        end else begin
            pres = mul32((32'd1048576 - 32'(rp)) - sra(b, 12), 32'd3125);
            if (!pres[31]) pres = (pres << 1) / a;
            else pres = (pres / a) * 32'd2;
            c = sra(mul32(p9, mul32(pres >> 3, pres >> 3) >> 13), 12);
            e = sra(mul32(pres >> 2, p8), 13);
            pres = pres + sra(c + e + p7, 4);
        end
        r.pres = pres;

        a = fine - 32'd76800;
        b = sra((32'(rh) << 14) - (h4 << 20) - mul32(h5, a) + 32'd16384, 15);
        c = sra(mul32(a, h6), 10);
        d = sra(mul32(a, h3), 11) + 32'd32768;
        e = sra(mul32(c, d), 10) + 32'd2097152;
        e = sra(mul32(e, h2) + 32'd8192, 14);
        a = mul32(b, e);
        c = sra(a, 15);
        a = a - sra(mul32(sra(mul32(c, c), 7), h1), 4);
        if (a[31]) a = 0;
        else if (a > 32'd419430400) a = 32'd419430400;
        r.hum = 17'(a >> 12);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        idle_cycles(FlushCycles);
    endtask

    // the write enable stays up between consecutive writes; load_cal drops it
    task automatic write_cal(input logic [esc_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            esc_pkg::REG_TEMP_CAL:       cal_temp = val[47:0];
            esc_pkg::REG_PRESS_CAL_LOW:  cal_plo = val;
            esc_pkg::REG_PRESS_CAL_HIGH: cal_phi = val;
            esc_pkg::REG_PRESS_CAL_LAST: cal_plast = val[15:0];
            esc_pkg::REG_HUM_CAL:        cal_hum = val;
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [63:0] tc, input logic [63:0] pl,
                            input logic [63:0] ph, input logic [63:0] pz,
                            input logic [63:0] hc);
        write_cal(esc_pkg::REG_TEMP_CAL, tc);
        write_cal(esc_pkg::REG_PRESS_CAL_LOW, pl);
        write_cal(esc_pkg::REG_PRESS_CAL_HIGH, ph);
        write_cal(esc_pkg::REG_PRESS_CAL_LAST, pz);
        write_cal(esc_pkg::REG_HUM_CAL, hc);
        i_cfg_we <= 0;
    endtask

    // a typical part's calibration
    task automatic load_typical_cal();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'hFFFF & -16'sd10, 16'd3024, 16'd36477},
                 {16'hFFFF & -16'sd12000, 16'd15500, 16'hFFF9, 16'd140},
                 64'hFFFF & -64'sd7000,
                 {8'd30, 12'd0, 12'd320, 8'd0, 16'd350, 8'd75});
    endtask

    // valid stays up after acceptance; a gap or a drain drops it
    task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                               input logic [15:0] rh);
        i_valid <= 1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        i_raw_humidity <= rh;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(compensate(rt, rp, rh));
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_gap_max == 0) return;
        if (r < 60) return;
        i_valid <= 0;
        if (r < 95) idle_cycles($urandom_range(1, tx_gap_max));
        else idle_cycles($urandom_range(20, 150));
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_sample(20'($urandom), 20'($urandom), 16'($urandom));
            random_gap();
        end
    endtask

    task automatic test_directed_extremes();
        // zero calibration: divisor is zero, pressure flagged invalid
        send_sample(20'h00000, 20'h00000, 16'h0000);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        wait_drained();
        load_typical_cal();
        send_sample(20'd519888, 20'd415148, 16'd28000);
        send_sample(20'h00000, 20'h00000, 16'h0000);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'hFFFFF, 20'h00000, 16'h0000);
        send_sample(20'h00000, 20'hFFFFF, 16'hFFFF);
        send_sample(20'h80000, 20'h80000, 16'h8000);
        wait_drained();
        // all-ones calibration
        load_cal(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
        send_sample(20'h00000, 20'h00000, 16'h0000);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'h55555, 20'hAAAAA, 16'h5555);
        wait_drained();
        // most-negative signed coefficients, max unsigned ones
        load_cal({16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 64'h8000800080008000, 64'h8000,
                 {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
        send_sample(20'hFFFFF, 20'h00000, 16'hFFFF);
        send_sample(20'h00000, 20'hFFFFF, 16'h0000);
        wait_drained();
        // unknown register index is ignored
        write_cal(3'd7, 64'hDEADBEEFDEADBEEF);
        write_cal(3'd5, 64'h123456789ABCDEF0);
        load_typical_cal();
        send_sample(20'd519888, 20'd415148, 16'd28000);
        wait_drained();
    endtask

    task automatic test_random_typical(input int n);
        load_typical_cal();
        send_random(n);
        wait_drained();
    endtask

    task automatic test_random_cal(input int phases, input int n);
        for (int p = 0; p < phases; p++) begin
            load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            send_random(n);
            wait_drained();
        end
    endtask

    task automatic test_back_pressure();
        load_typical_cal();
        tx_gap_max = 0;
        rx_random = 0;
        rx_hold = 1;
        fork
            begin
                idle_cycles(600);
                rx_hold = 0;
            end
            send_random(20);
        join
        rx_random = 1;
        tx_gap_max = 3;
        wait_drained();
        // sender pauses until drained between bursts
        for (int k = 0; k < 5; k++) begin
            send_random(3);
            wait_drained();
        end
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_ready <= 0;
        end else if (!rx_random) begin
            i_ready <= 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_comp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (want.inval) invalid_seen++;
                if (o_temperature_centi !== want.temp)
                    report_mismatch("temperature", o_temperature_centi, want.temp);
                if (o_pressure_pa !== want.pres)
                    report_mismatch("pressure", o_pressure_pa, want.pres);
                if (o_pressure_invalid !== want.inval)
                    report_mismatch("pressure_invalid", 32'(o_pressure_invalid),
                                    32'(want.inval));
                if (o_humidity_q10 !== want.hum)
                    report_mismatch("humidity", 32'(o_humidity_q10), 32'(want.hum));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cal_temp = 0; cal_plo = 0; cal_phi = 0; cal_plast = 0; cal_hum = 0;
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        i_valid = 0;
        i_raw_temperature = 0; i_raw_pressure = 0; i_raw_humidity = 0;
        idle_cycles(12);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_typical(300);
        test_random_cal(8, 40);
        test_back_pressure();
        idle_cycles(FlushCycles);
        if (expected_q.size() != 0) begin
            $display("%0d expected results never arrived", expected_q.size());
            errors++;
        end
        $display("checked %0d results (%0d with invalid pressure) over several calibrations",
                 results_seen, invalid_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
